// ----- hw/rtl/rhsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsi_pkg
// Shared constants, tables and types of the rgb to hsi pixel pipeline.
// ----------------------------------------------------------------------------
package rhsi_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int ANG_BITS     = 30;
	localparam int CORDIC_STEPS = 30;

	localparam int MAG_W   = 9;
	localparam int D_W     = 17;
	localparam int SQ_R    = FRAC_BITS + 9;
	localparam int SQ_IN_W = 2 * SQ_R;
	localparam int X_W     = FRAC_BITS + 1;
	localparam int DV_W    = 2 * FRAC_BITS + 8;
	localparam int CW      = ANG_BITS + 4;
	localparam int ZW      = ANG_BITS + 3;
	localparam int HUE_W   = 52;

	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [17:0] HUE_MUL     = 18'd255000;

	localparam logic [HUE_W-1:0] TURN255 = HUE_W'(6283 * 255) << ANG_BITS;

	// reciprocal of 6283 for the hue quotient, exact below 2^21
	localparam int          HUE_SHIFT = 34;
	localparam int          HQ_W      = HUE_SHIFT + 9;
	localparam logic [21:0] HUE_RECIP = 22'd2734342;

	localparam logic [X_W-1:0]     ONE    = X_W'(1) << FRAC_BITS;
	localparam logic [2*X_W-1:0]   ONE_SQ = (2 * X_W)'(1) << (2 * FRAC_BITS);

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             bleg;
		logic             gray;
		logic [7:0]       sat;
		logic [7:0]       inten;
		logic [X_W-1:0]   x;
	} ctx_t;

endpackage

// ----- hw/rtl/rhsi_sqrt.sv -----
// ----------------------------------------------------------------------------
// rhsi_sqrt
// Pipelined integer square root, one root bit per stage, with side context.
// ----------------------------------------------------------------------------
module rhsi_sqrt import rhsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [SQ_IN_W-1:0] in_val,
	input  ctx_t               in_ctx,
	output logic               out_valid,
	output logic [SQ_R-1:0]    out_root,
	output ctx_t               out_ctx
);

	logic               vld_s  [SQ_R];
	logic [SQ_IN_W-1:0] rem_s  [SQ_R];
	logic [SQ_IN_W-1:0] root_s [SQ_R];
	ctx_t               ctx_s  [SQ_R];

	logic               a_v    [SQ_R];
	logic [SQ_IN_W-1:0] a_rem  [SQ_R];
	logic [SQ_IN_W-1:0] a_root [SQ_R];
	ctx_t               a_ctx  [SQ_R];
	logic [SQ_IN_W-1:0] n_rem  [SQ_R];
	logic [SQ_IN_W-1:0] n_root [SQ_R];

	always_comb begin
		logic [SQ_IN_W-1:0] bitv;
		logic [SQ_IN_W-1:0] trial;
		for (int j = 0; j < SQ_R; j++) begin
			if (j == 0) begin
				a_v[j]    = in_valid;
				a_rem[j]  = in_val;
				a_root[j] = '0;
				a_ctx[j]  = in_ctx;
			end else begin
				a_v[j]    = vld_s[j-1];
				a_rem[j]  = rem_s[j-1];
				a_root[j] = root_s[j-1];
				a_ctx[j]  = ctx_s[j-1];
			end
			bitv  = SQ_IN_W'(1) << (2 * (SQ_R - 1 - j));
			trial = a_root[j] + bitv;
			if (a_rem[j] >= trial) begin
				n_rem[j]  = a_rem[j] - trial;
				n_root[j] = (a_root[j] >> 1) + bitv;
			end else begin
				n_rem[j]  = a_rem[j];
				n_root[j] = a_root[j] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SQ_R; j++) vld_s[j] <= 1'b0;
		end else begin
			for (int j = 0; j < SQ_R; j++) vld_s[j] <= a_v[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SQ_R; j++) begin
			rem_s[j]  <= n_rem[j];
			root_s[j] <= n_root[j];
			ctx_s[j]  <= a_ctx[j];
		end
	end

	assign out_valid = vld_s[SQ_R-1];
	assign out_root  = root_s[SQ_R-1][SQ_R-1:0];
	assign out_ctx   = ctx_s[SQ_R-1];

endmodule

// ----- hw/rtl/rhsi_cordic.sv -----
// ----------------------------------------------------------------------------
// rhsi_cordic
// Pipelined vectoring cordic, one rotation per stage, angle clamped to [0, pi/2].
// ----------------------------------------------------------------------------
module rhsi_cordic import rhsi_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [X_W-1:0] in_x,
	input  logic [X_W-1:0] in_y,
	input  ctx_t           in_ctx,
	output logic           out_valid,
	output logic [31:0]    out_phi,
	output ctx_t           out_ctx
);

	logic                 vld_s [CORDIC_STEPS];
	logic signed [CW-1:0] x_s   [CORDIC_STEPS];
	logic signed [CW-1:0] y_s   [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s   [CORDIC_STEPS];
	ctx_t                 ctx_s [CORDIC_STEPS];

	logic                 a_v   [CORDIC_STEPS];
	logic signed [CW-1:0] a_x   [CORDIC_STEPS];
	logic signed [CW-1:0] a_y   [CORDIC_STEPS];
	logic signed [ZW-1:0] a_z   [CORDIC_STEPS];
	ctx_t                 a_ctx [CORDIC_STEPS];
	logic signed [CW-1:0] n_x   [CORDIC_STEPS];
	logic signed [CW-1:0] n_y   [CORDIC_STEPS];
	logic signed [ZW-1:0] n_z   [CORDIC_STEPS];

	always_comb begin
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [ZW-1:0] step;
		for (int j = 0; j < CORDIC_STEPS; j++) begin
			if (j == 0) begin
				a_v[j]   = in_valid;
				a_x[j]   = signed'(CW'(in_x) << (ANG_BITS - FRAC_BITS));
				a_y[j]   = signed'(CW'(in_y) << (ANG_BITS - FRAC_BITS));
				a_z[j]   = '0;
				a_ctx[j] = in_ctx;
			end else begin
				a_v[j]   = vld_s[j-1];
				a_x[j]   = x_s[j-1];
				a_y[j]   = y_s[j-1];
				a_z[j]   = z_s[j-1];
				a_ctx[j] = ctx_s[j-1];
			end
			dx   = a_y[j] >>> j;
			dy   = a_x[j] >>> j;
			step = signed'(ZW'(ATAN_TAB[j]));
			if (!a_y[j][CW-1]) begin
				n_x[j] = a_x[j] + dx;
				n_y[j] = a_y[j] - dy;
				n_z[j] = a_z[j] + step;
			end else begin
				n_x[j] = a_x[j] - dx;
				n_y[j] = a_y[j] + dy;
				n_z[j] = a_z[j] - step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CORDIC_STEPS; j++) vld_s[j] <= 1'b0;
		end else begin
			for (int j = 0; j < CORDIC_STEPS; j++) vld_s[j] <= a_v[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < CORDIC_STEPS; j++) begin
			x_s[j]   <= n_x[j];
			y_s[j]   <= n_y[j];
			z_s[j]   <= n_z[j];
			ctx_s[j] <= a_ctx[j];
		end
	end

	always_comb begin
		if (z_s[CORDIC_STEPS-1][ZW-1]) begin
			out_phi = '0;
		end else if (z_s[CORDIC_STEPS-1] > signed'(ZW'(HALF_PI_Q30))) begin
			out_phi = HALF_PI_Q30;
		end else begin
			out_phi = z_s[CORDIC_STEPS-1][31:0];
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign out_ctx   = ctx_s[CORDIC_STEPS-1];

endmodule

// ----- hw/rtl/rgb_to_hsi_pixel.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel
// Fixed point rgb to hsi conversion of one pixel per clock.
//
//   channel  | handshake       | word
//   ---------+-----------------+-------------------------------
//   pixel in | start / busy    | blue, green, red
//   hsi out  | done            | hue, saturation, intensity
//
// one word per clock; the depth of the pipeline is set by the two bitwise square
// roots, the bitwise dividers and the cordic chain.
// busy is always low; the pipeline has no stall and the receiver takes done.
// reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel import rhsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       done,
	output logic [7:0] hue,
	output logic [7:0] saturation,
	output logic [7:0] intensity
);

	localparam int SD = 8;

	assign busy = 1'b0;

	// input register
	logic       vld_s1;
	logic [7:0] b_s1, g_s1, r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		b_s1 <= blue;
		g_s1 <= green;
		r_s1 <= red;
	end

	// sums, differences and the hue discriminant
	logic [9:0]         f_sum;
	logic [7:0]         f_min;
	logic signed [9:0]  f_a, f_c, f_gb;
	logic signed [10:0] f_n;
	logic signed [19:0] f_d;
	logic [19:0]        f_int;
	logic [9:0]         f_diff;
	ctx_t               f_ctx;

	always_comb begin
		f_sum  = 10'(b_s1) + 10'(g_s1) + 10'(r_s1);
		f_min  = (b_s1 < g_s1) ? b_s1 : g_s1;
		if (r_s1 < f_min) f_min = r_s1;
		f_a    = signed'({2'b00, r_s1}) - signed'({2'b00, g_s1});
		f_c    = signed'({2'b00, r_s1}) - signed'({2'b00, b_s1});
		f_gb   = signed'({2'b00, g_s1}) - signed'({2'b00, b_s1});
		f_d    = 20'(f_a * f_a) + 20'(f_c * f_gb);
		f_n    = signed'({2'b00, r_s1, 1'b0}) - signed'({3'b000, g_s1})
			- signed'({3'b000, b_s1});
		f_int  = 20'(f_sum) * 20'd683;
		f_diff = f_sum - 10'(3 * f_min);
		f_ctx.mag   = f_n[10] ? MAG_W'(-f_n) : MAG_W'(f_n);
		f_ctx.neg   = f_n[10];
		f_ctx.bleg  = (b_s1 <= g_s1);
		f_ctx.gray  = (f_d == '0);
		f_ctx.sat   = '0;
		f_ctx.inten = f_int[18:11];
		f_ctx.x     = '0;
	end

	logic             vld_s2;
	logic [9:0]       sum_s2;
	logic [17:0]      num_s2;
	logic [D_W-1:0]   d_s2;
	ctx_t             ctx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		sum_s2 <= f_sum;
		num_s2 <= (18'(f_diff) << 8) - 18'(f_diff);
		d_s2   <= f_d[D_W-1:0];
		ctx_s2 <= f_ctx;
	end

	// saturation divider, one quotient bit per stage
	logic           sv_s   [SD];
	logic [17:0]    srem_s [SD];
	logic [7:0]     sq_s   [SD];
	logic [9:0]     ssum_s [SD];
	logic [D_W-1:0] sd_s   [SD];
	ctx_t           sctx_s [SD];

	logic           sa_v   [SD];
	logic [17:0]    sa_rem [SD];
	logic [7:0]     sa_q   [SD];
	logic [9:0]     sa_sum [SD];
	logic [D_W-1:0] sa_d   [SD];
	ctx_t           sa_ctx [SD];
	logic [17:0]    sn_rem [SD];
	logic [7:0]     sn_q   [SD];

	always_comb begin
		logic [17:0] dv;
		for (int j = 0; j < SD; j++) begin
			if (j == 0) begin
				sa_v[j]   = vld_s2;
				sa_rem[j] = num_s2;
				sa_q[j]   = '0;
				sa_sum[j] = sum_s2;
				sa_d[j]   = d_s2;
				sa_ctx[j] = ctx_s2;
			end else begin
				sa_v[j]   = sv_s[j-1];
				sa_rem[j] = srem_s[j-1];
				sa_q[j]   = sq_s[j-1];
				sa_sum[j] = ssum_s[j-1];
				sa_d[j]   = sd_s[j-1];
				sa_ctx[j] = sctx_s[j-1];
			end
			dv        = 18'(sa_sum[j]) << (SD - 1 - j);
			sn_rem[j] = sa_rem[j];
			sn_q[j]   = sa_q[j];
			if (sa_rem[j] >= dv) begin
				sn_rem[j]             = sa_rem[j] - dv;
				sn_q[j][SD - 1 - j]   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SD; j++) sv_s[j] <= 1'b0;
		end else begin
			for (int j = 0; j < SD; j++) sv_s[j] <= sa_v[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SD; j++) begin
			srem_s[j] <= sn_rem[j];
			sq_s[j]   <= sn_q[j];
			ssum_s[j] <= sa_sum[j];
			sd_s[j]   <= sa_d[j];
			sctx_s[j] <= sa_ctx[j];
		end
	end

	// sqrt of the discriminant
	ctx_t             r1_in_ctx;
	logic             r1_v;
	logic [SQ_R-1:0]  r1_root;
	ctx_t             r1_ctx;

	always_comb begin
		r1_in_ctx     = sctx_s[SD-1];
		r1_in_ctx.sat = (ssum_s[SD-1] == '0) ? 8'd0 : sq_s[SD-1];
	end

	rhsi_sqrt u_sqrt_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sv_s[SD-1]),
		.in_val    (SQ_IN_W'(sd_s[SD-1]) << (2 * FRAC_BITS)),
		.in_ctx    (r1_in_ctx),
		.out_valid (r1_v),
		.out_root  (r1_root),
		.out_ctx   (r1_ctx)
	);

	// cosine divider, one quotient bit per stage
	logic             dv_s   [X_W];
	logic [DV_W-1:0]  drem_s [X_W];
	logic [SQ_R-1:0]  ds_s   [X_W];
	logic [X_W-1:0]   dq_s   [X_W];
	ctx_t             dctx_s [X_W];

	logic             da_v   [X_W];
	logic [DV_W-1:0]  da_rem [X_W];
	logic [SQ_R-1:0]  da_s   [X_W];
	logic [X_W-1:0]   da_q   [X_W];
	ctx_t             da_ctx [X_W];
	logic [DV_W-1:0]  dn_rem [X_W];
	logic [X_W-1:0]   dn_q   [X_W];

	always_comb begin
		logic [DV_W:0] cmp;
		for (int j = 0; j < X_W; j++) begin
			if (j == 0) begin
				da_v[j]   = r1_v;
				da_rem[j] = DV_W'(r1_ctx.mag) << (2 * FRAC_BITS - 1);
				da_s[j]   = r1_root;
				da_q[j]   = '0;
				da_ctx[j] = r1_ctx;
			end else begin
				da_v[j]   = dv_s[j-1];
				da_rem[j] = drem_s[j-1];
				da_s[j]   = ds_s[j-1];
				da_q[j]   = dq_s[j-1];
				da_ctx[j] = dctx_s[j-1];
			end
			cmp       = (DV_W + 1)'(da_s[j]) << (X_W - 1 - j);
			dn_rem[j] = da_rem[j];
			dn_q[j]   = da_q[j];
			if ({1'b0, da_rem[j]} >= cmp) begin
				dn_rem[j]            = da_rem[j] - cmp[DV_W-1:0];
				dn_q[j][X_W - 1 - j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < X_W; j++) dv_s[j] <= 1'b0;
		end else begin
			for (int j = 0; j < X_W; j++) dv_s[j] <= da_v[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < X_W; j++) begin
			drem_s[j] <= dn_rem[j];
			ds_s[j]   <= da_s[j];
			dq_s[j]   <= dn_q[j];
			dctx_s[j] <= da_ctx[j];
		end
	end

	// clamp and square of the cosine
	logic             xm_v_q;
	logic [2*X_W-1:0] xsq_q;
	ctx_t             xctx_q;
	logic [X_W-1:0]   x_cl;
	ctx_t             x_ctx;

	assign x_cl = (dq_s[X_W-1] > ONE) ? ONE : dq_s[X_W-1];

	always_comb begin
		x_ctx   = dctx_s[X_W-1];
		x_ctx.x = x_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) xm_v_q <= 1'b0;
		else         xm_v_q <= dv_s[X_W-1];
	end

	always_ff @(posedge clk) begin
		xsq_q  <= (2 * X_W)'(x_cl) * (2 * X_W)'(x_cl);
		xctx_q <= x_ctx;
	end

	// sine by square root
	logic             r2_v;
	logic [SQ_R-1:0]  r2_root;
	ctx_t             r2_ctx;

	rhsi_sqrt u_sqrt_s (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xm_v_q),
		.in_val    (SQ_IN_W'(ONE_SQ - xsq_q)),
		.in_ctx    (xctx_q),
		.out_valid (r2_v),
		.out_root  (r2_root),
		.out_ctx   (r2_ctx)
	);

	// angle
	logic        c_v;
	logic [31:0] c_phi;
	ctx_t        c_ctx;

	rhsi_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r2_v),
		.in_x      (r2_ctx.x),
		.in_y      (r2_root[X_W-1:0]),
		.in_ctx    (r2_ctx),
		.out_valid (c_v),
		.out_phi   (c_phi),
		.out_ctx   (c_ctx)
	);

	// angle to turn fraction
	logic             t_v_s1, t_v_s2, t_v_s3;
	logic [31:0]      theta_s1;
	logic [HUE_W-1:0] prod_s2, hv_s3;
	ctx_t             t_ctx_s1, t_ctx_s2, t_ctx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_v_s1 <= 1'b0;
			t_v_s2 <= 1'b0;
			t_v_s3 <= 1'b0;
		end else begin
			t_v_s1 <= c_v;
			t_v_s2 <= t_v_s1;
			t_v_s3 <= t_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		theta_s1 <= c_ctx.neg ? (PI_Q30 - c_phi) : c_phi;
		t_ctx_s1 <= c_ctx;
		prod_s2  <= HUE_W'(theta_s1 * 50'(HUE_MUL));
		t_ctx_s2 <= t_ctx_s1;
		hv_s3    <= t_ctx_s2.bleg ? prod_s2 : (TURN255 - prod_s2);
		t_ctx_s3 <= t_ctx_s2;
	end

	// hue quotient by reciprocal multiplication
	logic [HQ_W-1:0] h_prod;

	assign h_prod = HQ_W'(hv_s3[HUE_W-2:ANG_BITS]) * HQ_W'(HUE_RECIP);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= t_v_s3;
	end

	always_ff @(posedge clk) begin
		hue        <= t_ctx_s3.gray ? 8'd0 : h_prod[HUE_SHIFT+7:HUE_SHIFT];
		saturation <= t_ctx_s3.sat;
		intensity  <= t_ctx_s3.inten;
	end

endmodule
